// ===== hw/rtl/i2a_pkg.sv =====
// Shared types, codes and character helpers for the integer to ASCII formatter.
package i2a_pkg;

  localparam int VALUE_W  = 64;
  localparam int ACTION_W = 2;
  localparam int CHAR_W   = 8;
  localparam int NIL_LEN  = 5;

  localparam logic [ACTION_W-1:0] ACT_DEC    = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_HEX_LO = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_HEX_UP = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_PTR    = 2'd3;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CH_X    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_A_LO = 8'h61;
  localparam logic [CHAR_W-1:0] CH_A_UP = 8'h41;

  typedef enum logic [2:0] {
    KIND_DEC,
    KIND_HEX_LO,
    KIND_HEX_UP,
    KIND_PTR,
    KIND_NIL,
    KIND_ZERO
  } kind_t;

  localparam int KIND_W = $bits(kind_t);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DABBLE,
    ST_DIGITS,
    ST_PFX0,
    ST_PFXX,
    ST_NIL,
    ST_ZERO
  } state_t;

  function automatic int dec_digits(int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

  function automatic int hex_digits(int bits);
    return (bits + 3) / 4;
  endfunction

  function automatic int max2(int a, int b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(logic [3:0] d, logic upper);
    logic [CHAR_W-1:0] base;
    base = upper ? CH_A_UP : CH_A_LO;
    if (d <= 4'd9) begin
      return CH_ZERO + {4'h0, d};
    end else begin
      return base + {4'h0, d} - 8'd10;
    end
  endfunction

  function automatic logic [CHAR_W-1:0] nil_char(logic [2:0] i);
    logic [CHAR_W-1:0] c;
    unique case (i)
      3'd0:    c = 8'h28;
      3'd1:    c = 8'h6e;
      3'd2:    c = 8'h69;
      3'd3:    c = 8'h6c;
      default: c = 8'h29;
    endcase
    return c;
  endfunction

endpackage

// ===== hw/rtl/integer_to_ascii_formatter.sv =====
// Top level of the integer to ASCII formatter.
// Each input item is a value and a format code; the block sends its text one character per
// output item, most significant digit first, leading zeros suppressed, with tlast on the final
// character. A two-entry queue lets the input side take items while text is still going out.
// The character engine handles one item at a time, taking it from the queue while idle, then:
// decimal runs NUMBER_BITS shift steps of shift-and-add-3 conversion, then steps through each
// decimal digit position; hex steps through each nibble position; pointer sends a "0x" prefix
// and then steps through each nibble position; "(nil)" is sent character by character; a lone
// zero is a single character. Character output waits while the output is stalled.
module integer_to_ascii_formatter #(
  parameter int NUMBER_BITS  = 32,
  parameter int POINTER_BITS = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [i2a_pkg::ACTION_W-1:0]  s_tuser,   // [1:0] action
  input  logic [i2a_pkg::VALUE_W-1:0]   s_tdata,   // [63:0] value
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [i2a_pkg::CHAR_W-1:0]    m_tdata,   // [7:0] out_char
  output logic                          m_tlast
);
  import i2a_pkg::*;

  localparam int VAL_W = 4 * max2(hex_digits(NUMBER_BITS), hex_digits(POINTER_BITS));
  localparam int Q_W   = KIND_W + VAL_W;

  logic           q_wr;
  logic           q_rd;
  logic           q_full;
  logic           q_empty;
  logic [Q_W-1:0] q_wdata;
  logic [Q_W-1:0] q_rdata;

  i2a_front #(
    .NUMBER_BITS  (NUMBER_BITS),
    .POINTER_BITS (POINTER_BITS),
    .VAL_W        (VAL_W)
  ) u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .s_tdata  (s_tdata),
    .q_full   (q_full),
    .q_wr     (q_wr),
    .q_data   (q_wdata)
  );

  i2a_fifo #(
    .W (Q_W)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  i2a_back #(
    .NUMBER_BITS  (NUMBER_BITS),
    .POINTER_BITS (POINTER_BITS),
    .VAL_W        (VAL_W)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_data   (q_rdata),
    .q_rd     (q_rd),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

// ===== hw/rtl/i2a_fifo.sv =====
// Two-entry queue between the classifying front end and the character back end.
module i2a_fifo #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         wr,
  input  logic [W-1:0] wdata,
  input  logic         rd,
  output logic [W-1:0] rdata,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] mem [2];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign rdata = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr) begin
      mem[wptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr) begin
        wptr <= ~wptr;
      end
      if (rd) begin
        rptr <= ~rptr;
      end
      count <= count + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== hw/rtl/i2a_front.sv =====
// Front end: accepts items, masks the value to its format width and classifies it.
module i2a_front #(
  parameter int NUMBER_BITS  = 32,
  parameter int POINTER_BITS = 64,
  parameter int VAL_W        = 64
) (
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [i2a_pkg::ACTION_W-1:0]  s_tuser,
  input  logic [i2a_pkg::VALUE_W-1:0]   s_tdata,
  input  logic                          q_full,
  output logic                          q_wr,
  output logic [i2a_pkg::KIND_W+VAL_W-1:0] q_data
);
  import i2a_pkg::*;

  logic [VAL_W-1:0] num_val;
  logic [VAL_W-1:0] ptr_val;
  logic [VAL_W-1:0] val;
  kind_t            kind;

  assign s_tready = ~q_full;
  assign q_wr     = s_tvalid & ~q_full;

  assign num_val = VAL_W'(s_tdata[NUMBER_BITS-1:0]);
  assign ptr_val = VAL_W'(s_tdata[POINTER_BITS-1:0]);

  always_comb begin
    val  = num_val;
    kind = KIND_DEC;
    unique case (s_tuser)
      ACT_PTR: begin
        val  = ptr_val;
        kind = (ptr_val == '0) ? KIND_NIL : KIND_PTR;
      end
      ACT_HEX_LO: kind = (num_val == '0) ? KIND_ZERO : KIND_HEX_LO;
      ACT_HEX_UP: kind = (num_val == '0) ? KIND_ZERO : KIND_HEX_UP;
      default:    kind = (num_val == '0) ? KIND_ZERO : KIND_DEC;
    endcase
  end

  assign q_data = {kind, val};

endmodule

// ===== hw/rtl/i2a_back.sv =====
// Back end: converts one queued item to characters and drives the output register.
module i2a_back #(
  parameter int NUMBER_BITS  = 32,
  parameter int POINTER_BITS = 64,
  parameter int VAL_W        = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             q_empty,
  input  logic [i2a_pkg::KIND_W+VAL_W-1:0] q_data,
  output logic                             q_rd,
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [i2a_pkg::CHAR_W-1:0]       m_tdata,
  output logic                             m_tlast
);
  import i2a_pkg::*;

  localparam int DEC_N  = dec_digits(NUMBER_BITS);
  localparam int HEX_N  = hex_digits(NUMBER_BITS);
  localparam int PTR_N  = hex_digits(POINTER_BITS);
  localparam int MAX_N  = max2(max2(DEC_N, HEX_N), max2(PTR_N, NIL_LEN));
  localparam int IDX_W  = $clog2(MAX_N);
  localparam int CNT_W  = $clog2(NUMBER_BITS);
  localparam int BCD_W  = 4 * DEC_N;

  localparam logic [IDX_W-1:0] DEC_TOP = IDX_W'(DEC_N - 1);
  localparam logic [IDX_W-1:0] HEX_TOP = IDX_W'(HEX_N - 1);
  localparam logic [IDX_W-1:0] PTR_TOP = IDX_W'(PTR_N - 1);
  localparam logic [IDX_W-1:0] NIL_TOP = IDX_W'(NIL_LEN - 1);
  localparam logic [CNT_W-1:0] CNT_TOP = CNT_W'(NUMBER_BITS - 1);

  state_t                 state, state_next;
  logic                   is_dec, is_dec_next;
  logic                   upper, upper_next;
  logic                   started, started_next;
  logic [IDX_W-1:0]       idx, idx_next;
  logic [CNT_W-1:0]       cnt, cnt_next;
  logic [VAL_W-1:0]       val, val_next;
  logic [BCD_W-1:0]       bcd, bcd_next;
  logic [NUMBER_BITS-1:0] bin, bin_next;

  kind_t            q_kind;
  logic [VAL_W-1:0] q_val;
  logic [BCD_W-1:0] bcd_adj;
  logic [3:0]       digit;
  logic             slot_free;
  logic             emit;
  logic [CHAR_W-1:0] emit_char;
  logic             emit_last;

  assign q_kind    = kind_t'(q_data[KIND_W+VAL_W-1:VAL_W]);
  assign q_val     = q_data[VAL_W-1:0];
  assign slot_free = ~m_tvalid | m_tready;
  assign digit     = is_dec ? bcd[{idx, 2'b00} +: 4] : val[{idx, 2'b00} +: 4];

  always_comb begin
    for (int i = 0; i < DEC_N; i++) begin
      bcd_adj[4*i +: 4] = (bcd[4*i +: 4] >= 4'd5) ? bcd[4*i +: 4] + 4'd3 : bcd[4*i +: 4];
    end
  end

  always_comb begin
    state_next   = state;
    is_dec_next  = is_dec;
    upper_next   = upper;
    started_next = started;
    idx_next     = idx;
    cnt_next     = cnt;
    val_next     = val;
    bcd_next     = bcd;
    bin_next     = bin;
    q_rd         = 1'b0;
    emit         = 1'b0;
    emit_char    = CH_ZERO;
    emit_last    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (!q_empty) begin
          q_rd         = 1'b1;
          val_next     = q_val;
          started_next = 1'b0;
          is_dec_next  = 1'b0;
          upper_next   = 1'b0;
          unique case (q_kind)
            KIND_DEC: begin
              bin_next    = q_val[NUMBER_BITS-1:0];
              bcd_next    = '0;
              cnt_next    = '0;
              is_dec_next = 1'b1;
              idx_next    = DEC_TOP;
              state_next  = ST_DABBLE;
            end
            KIND_HEX_LO: begin
              idx_next   = HEX_TOP;
              state_next = ST_DIGITS;
            end
            KIND_HEX_UP: begin
              idx_next   = HEX_TOP;
              upper_next = 1'b1;
              state_next = ST_DIGITS;
            end
            KIND_PTR: begin
              idx_next   = PTR_TOP;
              state_next = ST_PFX0;
            end
            KIND_NIL: begin
              idx_next   = '0;
              state_next = ST_NIL;
            end
            default: state_next = ST_ZERO;
          endcase
        end
      end
      ST_DABBLE: begin
        bcd_next = {bcd_adj[BCD_W-2:0], bin[NUMBER_BITS-1]};
        bin_next = bin << 1;
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_TOP) begin
          state_next = ST_DIGITS;
        end
      end
      ST_DIGITS: begin
        if (slot_free) begin
          if (digit != 4'd0 || started || idx == '0) begin
            emit         = 1'b1;
            emit_char    = is_dec ? CH_ZERO + {4'h0, digit} : hex_char(digit, upper);
            emit_last    = (idx == '0);
            started_next = 1'b1;
          end
          if (idx == '0) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx - 1'b1;
          end
        end
      end
      ST_PFX0: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_char  = CH_ZERO;
          state_next = ST_PFXX;
        end
      end
      ST_PFXX: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_char  = CH_X;
          state_next = ST_DIGITS;
        end
      end
      ST_NIL: begin
        if (slot_free) begin
          emit      = 1'b1;
          emit_char = nil_char(3'(idx));
          emit_last = (idx == NIL_TOP);
          if (idx == NIL_TOP) begin
            state_next = ST_IDLE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_ZERO: begin
        if (slot_free) begin
          emit       = 1'b1;
          emit_char  = CH_ZERO;
          emit_last  = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    is_dec  <= is_dec_next;
    upper   <= upper_next;
    started <= started_next;
    idx     <= idx_next;
    cnt     <= cnt_next;
    val     <= val_next;
    bcd     <= bcd_next;
    bin     <= bin_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= emit_char;
      m_tlast <= emit_last;
    end
  end

endmodule
